### design/wmta_pkg.sv
// Shared types, codes and the saturating adder of the morph target accumulator.
package wmta_pkg;

   // Action codes carried by an input word.
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_APPLY = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // Rounding bias and limits of the Q16.16 sum.
   localparam logic signed [47:0] ROUND_BIAS = 48'sd8192;
   localparam logic signed [34:0] SUM_MAX    = 35'sd2147483647;
   localparam logic signed [34:0] SUM_MIN    = -35'sd2147483648;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [11:0]        vertex_index;
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
      logic signed [31:0] value_z;
      logic signed [15:0] weight;
      logic               is_basic;
   } item_type;

   typedef struct packed {
      vec_type pos;
      vec_type basic;
      logic    skipped;
      logic    saturated;
   } result_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clip;
   } sat_type;

   // Adds a rounded product to a stored value and clips to the Q16.16 range.
   function automatic sat_type sat_add(input logic signed [31:0] a,
                                       input logic signed [33:0] d);
      logic signed [34:0] s;
      sat_type            r;
      s = 35'(a) + 35'(d);
      if (s > SUM_MAX) begin
         r.value = 32'sh7FFF_FFFF;
         r.clip  = 1'b1;
      end else if (s < SUM_MIN) begin
         r.value = 32'sh8000_0000;
         r.clip  = 1'b1;
      end else begin
         r.value = s[31:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

endpackage

### design/wmta_req_if.sv
// Request channel: one word per item with its action, vertex and operands.
interface wmta_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [11:0]        vertex_index;
   logic signed [31:0] value_x;
   logic signed [31:0] value_y;
   logic signed [31:0] value_z;
   logic signed [15:0] weight;
   logic               is_basic;

   modport source (output valid, action, vertex_index, value_x, value_y, value_z, weight,
                   is_basic, input ready);
   modport sink (input valid, action, vertex_index, value_x, value_y, value_z, weight,
                 is_basic, output ready);
endinterface

### design/wmta_rsp_if.sv
// Response channel: one word per item with the updated vertex and flags.
interface wmta_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_out_x;
   logic signed [31:0] pos_out_y;
   logic signed [31:0] pos_out_z;
   logic signed [31:0] basic_out_x;
   logic signed [31:0] basic_out_y;
   logic signed [31:0] basic_out_z;
   logic               skipped;
   logic               saturated;

   modport source (output valid, pos_out_x, pos_out_y, pos_out_z, basic_out_x, basic_out_y,
                   basic_out_z, skipped, saturated, input ready);
   modport sink (input valid, pos_out_x, pos_out_y, pos_out_z, basic_out_x, basic_out_y,
                 basic_out_z, skipped, saturated, output ready);
endinterface

### design/wmta_csr_if.sv
// Configuration channel: writes the minimum weight register.
interface wmta_csr_if;
   logic        valid;
   logic        ready;
   logic [14:0] min_weight;

   modport source (output valid, min_weight, input ready);
   modport sink (input valid, min_weight, output ready);
endinterface

### design/wmta_store.sv
// Synchronous vertex store: one write port and one registered read port.
module wmta_store
   import wmta_pkg::*;
#(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output vec_type                  rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  vec_type                  wr_data
);

   vec_type mem [DEPTH];
   vec_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/wmta_datapath.sv
// Weight scaling, rounding, saturating accumulation and result assembly.
module wmta_datapath
   import wmta_pkg::*;
(
   input  logic        clock,
   input  logic        prod_en,
   input  item_type    item,
   input  logic        in_range,
   input  logic [14:0] min_weight,
   input  vec_type     pos_rd,
   input  vec_type     basic_rd,
   output vec_type     pos_wr,
   output vec_type     basic_wr,
   output logic        pos_we,
   output logic        basic_we,
   output result_type  result
);

   logic signed [47:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [47:0] prod_x_in, prod_y_in, prod_z_in;
   logic               skip_ff, skip_in;
   logic [16:0]        weight_mag;
   logic signed [47:0] rnd_x, rnd_y, rnd_z;
   logic signed [33:0] delta_x, delta_y, delta_z;
   sat_type            sum_px, sum_py, sum_pz, sum_bx, sum_by, sum_bz;
   logic               is_load, is_apply, do_apply, clip_pos, clip_basic;

   // Product stage: three 16 by 32 multiplies and the weight threshold test.
   always_comb begin
      prod_x_in  = item.weight * item.value_x;
      prod_y_in  = item.weight * item.value_y;
      prod_z_in  = item.weight * item.value_z;
      weight_mag = item.weight[15] ? 17'(-18'(item.weight)) : 17'(item.weight);
      skip_in    = weight_mag < 17'(min_weight);
   end

   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         skip_ff   <= skip_in;
      end
   end

   // Round the Q.30 products to Q16.16, nearest with ties upward.
   always_comb begin
      rnd_x   = prod_x_ff + ROUND_BIAS;
      rnd_y   = prod_y_ff + ROUND_BIAS;
      rnd_z   = prod_z_ff + ROUND_BIAS;
      delta_x = rnd_x[47:14];
      delta_y = rnd_y[47:14];
      delta_z = rnd_z[47:14];
   end

   // Saturating sums against the stored position and basic offset.
   always_comb begin
      sum_px = sat_add(pos_rd.x, delta_x);
      sum_py = sat_add(pos_rd.y, delta_y);
      sum_pz = sat_add(pos_rd.z, delta_z);
      sum_bx = sat_add(basic_rd.x, delta_x);
      sum_by = sat_add(basic_rd.y, delta_y);
      sum_bz = sat_add(basic_rd.z, delta_z);
   end

   // Decode the action; unused codes behave as a read.
   always_comb begin
      case (item.action)
         ACT_LOAD: begin
            is_load  = 1'b1;
            is_apply = 1'b0;
         end
         ACT_APPLY: begin
            is_load  = 1'b0;
            is_apply = 1'b1;
         end
         default: begin
            is_load  = 1'b0;
            is_apply = 1'b0;
         end
      endcase
   end

   // Write-back data and enables, and the result word.
   always_comb begin
      do_apply   = in_range && is_apply && !skip_ff;
      clip_pos   = sum_px.clip || sum_py.clip || sum_pz.clip;
      clip_basic = sum_bx.clip || sum_by.clip || sum_bz.clip;
      pos_we     = in_range && (is_load || do_apply);
      basic_we   = in_range && (is_load || (do_apply && item.is_basic));

      if (is_load) begin
         pos_wr.x = item.value_x;
         pos_wr.y = item.value_y;
         pos_wr.z = item.value_z;
         basic_wr = '0;
      end else begin
         pos_wr.x   = sum_px.value;
         pos_wr.y   = sum_py.value;
         pos_wr.z   = sum_pz.value;
         basic_wr.x = sum_bx.value;
         basic_wr.y = sum_by.value;
         basic_wr.z = sum_bz.value;
      end

      if (in_range) begin
         result.pos       = pos_we ? pos_wr : pos_rd;
         result.basic     = basic_we ? basic_wr : basic_rd;
         result.skipped   = is_apply && skip_ff;
         result.saturated = do_apply && (clip_pos || (item.is_basic && clip_basic));
      end else begin
         result = '0;
      end
   end

endmodule

### design/weighted_morph_target_accumulator.sv
// Top level of the weighted morph target accumulator: sequencer, stores and result register.
//
// Each request word runs a read-modify-write of one vertex through two synchronous stores,
// one for positions and one for basic offsets. An item passes three steps: the store read,
// the product register of the three weight multiplies, and the saturating add with write-back;
// a new word is accepted only once the previous item has been written back. The response
// sits in an output register, so the next word enters while a finished result waits; the
// write-back of an item stalls only when that register is still full. Stores are not
// cleared after reset: a vertex must be loaded before it is applied to or read.
module weighted_morph_target_accumulator
   import wmta_pkg::*;
#(
   parameter int VERTEX_COUNT = 4096
) (
   input logic              clock,
   input logic              reset,
   wmta_req_if.sink         req_ch,
   wmta_rsp_if.source       rsp_ch,
   wmta_csr_if.sink         csr_ch
);

   localparam int ADDR_W = $clog2(VERTEX_COUNT);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [14:0] min_weight_ff, min_weight_in;
   item_type    item_ff, item_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   logic        req_take, out_free, finish, in_range;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   vec_type     pos_rd, basic_rd, pos_wr, basic_wr;
   logic        pos_we, basic_we;
   result_type  result;

   // Handshakes.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign finish       = (state_ff == ST_FIN) && out_free;

   // Capture the incoming word.
   always_comb begin
      item_in.action       = req_ch.action;
      item_in.vertex_index = req_ch.vertex_index;
      item_in.value_x      = req_ch.value_x;
      item_in.value_y      = req_ch.value_y;
      item_in.value_z      = req_ch.value_z;
      item_in.weight       = req_ch.weight;
      item_in.is_basic     = req_ch.is_basic;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   // Store addresses and range check of the addressed vertex.
   assign rd_addr  = ADDR_W'(req_ch.vertex_index);
   assign wr_addr  = ADDR_W'(item_ff.vertex_index);
   assign in_range = 17'(item_ff.vertex_index) < 17'(VERTEX_COUNT);

   // Sequencer: read, multiply, then add and write back.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_MUL;
         ST_MUL:  state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Minimum weight register.
   assign min_weight_in = csr_ch.valid ? csr_ch.min_weight : min_weight_ff;

   // Response register.
   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_data_in = finish ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_weight_ff <= 15'd1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         min_weight_ff <= min_weight_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Position and basic offset stores.
   wmta_store #(.DEPTH(VERTEX_COUNT)) u_pos_store (
      .clock   (clock),
      .rd_en   (req_take),
      .rd_addr (rd_addr),
      .rd_data (pos_rd),
      .wr_en   (finish && pos_we),
      .wr_addr (wr_addr),
      .wr_data (pos_wr)
   );

   wmta_store #(.DEPTH(VERTEX_COUNT)) u_basic_store (
      .clock   (clock),
      .rd_en   (req_take),
      .rd_addr (rd_addr),
      .rd_data (basic_rd),
      .wr_en   (finish && basic_we),
      .wr_addr (wr_addr),
      .wr_data (basic_wr)
   );

   // Arithmetic.
   wmta_datapath u_datapath (
      .clock      (clock),
      .prod_en    (state_ff == ST_MUL),
      .item       (item_ff),
      .in_range   (in_range),
      .min_weight (min_weight_ff),
      .pos_rd     (pos_rd),
      .basic_rd   (basic_rd),
      .pos_wr     (pos_wr),
      .basic_wr   (basic_wr),
      .pos_we     (pos_we),
      .basic_we   (basic_we),
      .result     (result)
   );

   // Response outputs.
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pos_out_x   = rsp_data_ff.pos.x;
   assign rsp_ch.pos_out_y   = rsp_data_ff.pos.y;
   assign rsp_ch.pos_out_z   = rsp_data_ff.pos.z;
   assign rsp_ch.basic_out_x = rsp_data_ff.basic.x;
   assign rsp_ch.basic_out_y = rsp_data_ff.basic.y;
   assign rsp_ch.basic_out_z = rsp_data_ff.basic.z;
   assign rsp_ch.skipped     = rsp_data_ff.skipped;
   assign rsp_ch.saturated   = rsp_data_ff.saturated;

   // A stored vertex changes only in the write-back step of the sequence.
   assert property (@(posedge clock) disable iff (reset)
      (finish && (pos_we || basic_we)) |-> (state_ff == ST_FIN))
      else $error("store written outside the write-back step");

   // An accepted word always moves on to the product step.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_MUL))
      else $error("accepted word did not enter the product step");

   // A completed write-back always presents a response word.
   assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished item produced no response");

   // A skipped item performs no sum, so it cannot report saturation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.skipped && rsp_data_ff.saturated))
      else $error("response both skipped and saturated");

endmodule

### tb/wmta_vertex_checker.sv
// Checker of the morph target accumulator: follows every channel, predicts each result word and compares it.
module wmta_vertex_checker
   import wmta_pkg::*;
#(
   parameter int VERTEX_COUNT = 4096
) (
   input  logic clock,
   input  logic reset,
   wmta_req_if  req_ch,
   wmta_rsp_if  rsp_ch,
   wmta_csr_if  csr_ch,
   output int   mismatch_count,
   output int   results_owed
);

   localparam longint Q_HI = 64'sd2147483647;
   localparam longint Q_LO = -64'sd2147483648;

   // Shadow copy of both vertex stores and of the weight threshold.
   vec_type     pos_store [VERTEX_COUNT];
   vec_type     basic_store [VERTEX_COUNT];
   logic [14:0] weight_floor;

   // Vertex results still owed by the block, oldest first.
   result_type  expected_vertex_q [$];

   // Q1.14 weight times Q16.16 offset, rounded to nearest with ties going upwards.
   function automatic longint scaled_offset(input logic signed [15:0] w,
                                            input logic signed [31:0] v);
      longint p;
      p = longint'(w) * longint'(v) + 64'sd8192;
      return p >>> 14;
   endfunction

   // Adds an offset to a stored coordinate and clips the sum to the Q16.16 range.
   function automatic logic signed [31:0] clipped_sum(input logic signed [31:0] a,
                                                      input longint d,
                                                      inout logic clip);
      longint s;
      s = longint'(a) + d;
      if (s > Q_HI) begin
         clip = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (s < Q_LO) begin
         clip = 1'b1;
         return 32'sh8000_0000;
      end
      return s[31:0];
   endfunction

   // Applies one request word to the shadow stores and returns the vertex it reports.
   function automatic result_type predict_vertex(input item_type it);
      result_type  r;
      longint      dx;
      longint      dy;
      longint      dz;
      int          magnitude;
      int unsigned i;
      logic        clip;
      r    = '0;
      clip = 1'b0;
      i    = it.vertex_index;
      if (i >= VERTEX_COUNT) begin
         return r;
      end
      case (it.action)
         ACT_LOAD: begin
            pos_store[i]   = '{it.value_x, it.value_y, it.value_z};
            basic_store[i] = '0;
         end
         ACT_APPLY: begin
            magnitude = (it.weight < 0) ? -int'(it.weight) : int'(it.weight);
            if (magnitude < int'(weight_floor)) begin
               r.skipped = 1'b1;
            end else begin
               dx = scaled_offset(it.weight, it.value_x);
               dy = scaled_offset(it.weight, it.value_y);
               dz = scaled_offset(it.weight, it.value_z);
               pos_store[i].x = clipped_sum(pos_store[i].x, dx, clip);
               pos_store[i].y = clipped_sum(pos_store[i].y, dy, clip);
               pos_store[i].z = clipped_sum(pos_store[i].z, dz, clip);
               if (it.is_basic) begin
                  basic_store[i].x = clipped_sum(basic_store[i].x, dx, clip);
                  basic_store[i].y = clipped_sum(basic_store[i].y, dy, clip);
                  basic_store[i].z = clipped_sum(basic_store[i].z, dz, clip);
               end
            end
         end
         default: begin
            // A read, and the spare action code, leave the stores alone.
         end
      endcase
      r.pos       = pos_store[i];
      r.basic     = basic_store[i];
      r.saturated = clip;
      return r;
   endfunction

   // Reports one differing field and tells the caller whether it differed.
   function automatic int field_differs(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Every handshake is taken at the rising edge, before the block updates its outputs.
   always @(posedge clock) begin : watch
      item_type   it;
      result_type seen;
      result_type want;
      if (reset) begin
         weight_floor = 15'd1;
         expected_vertex_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            weight_floor = csr_ch.min_weight;
         end
         if (req_ch.valid && req_ch.ready) begin
            it.action       = req_ch.action;
            it.vertex_index = req_ch.vertex_index;
            it.value_x      = req_ch.value_x;
            it.value_y      = req_ch.value_y;
            it.value_z      = req_ch.value_z;
            it.weight       = req_ch.weight;
            it.is_basic     = req_ch.is_basic;
            expected_vertex_q.push_back(predict_vertex(it));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.pos.x     = rsp_ch.pos_out_x;
            seen.pos.y     = rsp_ch.pos_out_y;
            seen.pos.z     = rsp_ch.pos_out_z;
            seen.basic.x   = rsp_ch.basic_out_x;
            seen.basic.y   = rsp_ch.basic_out_y;
            seen.basic.z   = rsp_ch.basic_out_z;
            seen.skipped   = rsp_ch.skipped;
            seen.saturated = rsp_ch.saturated;
            if (expected_vertex_q.size() == 0) begin
               $error("result word arrived with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_vertex_q.pop_front();
               mismatch_count += field_differs("pos_out_x", want.pos.x, seen.pos.x)
                               + field_differs("pos_out_y", want.pos.y, seen.pos.y)
                               + field_differs("pos_out_z", want.pos.z, seen.pos.z)
                               + field_differs("basic_out_x", want.basic.x, seen.basic.x)
                               + field_differs("basic_out_y", want.basic.y, seen.basic.y)
                               + field_differs("basic_out_z", want.basic.z, seen.basic.z)
                               + field_differs("skipped", want.skipped, seen.skipped)
                               + field_differs("saturated", want.saturated, seen.saturated);
            end
         end
      end
      results_owed = expected_vertex_q.size();
   end

endmodule

### tb/tb_weighted_morph_target_accumulator.sv
// Testbench top of the morph target accumulator: clock, reset, stimulus, flow control and verdict.
module tb_weighted_morph_target_accumulator;
   import wmta_pkg::*;

   localparam logic [1:0]         ACT_SPARE   = 2'd3;
   localparam logic signed [31:0] Q_MAX       = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN       = 32'sh8000_0000;
   localparam int                 HOT_COUNT   = 24;
   localparam int                 PHASE_ITEMS = 360;
   localparam int                 LONG_HOLD   = 80;
   localparam int                 PHASES      = 5;

   logic        clock = 1'b0;
   logic        reset;
   int          mismatch_count;
   int          results_owed;
   int          rsp_idle_pct = 19;
   bit          hold_go = 1'b0;
   bit          hold_seen = 1'b0;
   int          hold_left = 0;
   logic [14:0] cur_min_weight = 15'd1;
   logic [11:0] hot_index [HOT_COUNT];

   wmta_req_if req_ch ();
   wmta_rsp_if rsp_ch ();
   wmta_csr_if csr_ch ();

   weighted_morph_target_accumulator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   wmta_vertex_checker vertex_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always #6 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #6_000_000;
      $display("weighted_morph_target_accumulator verification failed");
      $finish;
   end

   // Result side: random back-pressure, plus one long hold-off when the stimulus asks for it.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Offers one request word after a random gap and returns at the falling edge after it is taken.
   // Valid is left high so that a following word goes out without a bubble.
   task automatic offer_item(input logic [1:0] act, input logic [11:0] idx,
                             input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic signed [15:0] w,
                             input logic basic, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.vertex_index <= idx;
      req_ch.value_x      <= x;
      req_ch.value_y      <= y;
      req_ch.value_z      <= z;
      req_ch.weight       <= w;
      req_ch.is_basic     <= basic;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Stops offering words and waits until every outstanding result has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
   endtask

   // Writes the weight threshold while the block is idle.
   task automatic write_min_weight(input logic [14:0] value);
      drain_results();
      // Quiet cycles separate the last word from the register write.
      repeat (4) @(negedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.min_weight <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid   <= 1'b0;
      cur_min_weight = value;
   endtask

   // Q16.16 operand: full range, small and mid magnitudes, or an extreme.
   function automatic logic signed [31:0] random_q16();
      int unsigned pick;
      logic signed [31:0] v;
      pick = $urandom_range(99);
      if (pick < 40) begin
         v = $urandom;
      end else if (pick < 70) begin
         v = int'($urandom_range(2097151)) - 1048576;
      end else if (pick < 85) begin
         v = int'($urandom_range(536870911)) - 268435456;
      end else begin
         case ($urandom_range(4))
            0: v = Q_MAX;
            1: v = Q_MIN;
            2: v = 32'sd0;
            3: v = 32'sd1;
            default: v = -32'sd1;
         endcase
      end
      return v;
   endfunction

   // Q1.14 weight: full range, close to the current threshold, small, or an extreme.
   function automatic logic signed [15:0] random_weight();
      int unsigned pick;
      int m;
      logic signed [15:0] w;
      pick = $urandom_range(99);
      if (pick < 45) begin
         w = 16'($urandom);
      end else if (pick < 70) begin
         m = int'(cur_min_weight) + int'($urandom_range(4)) - 2;
         if (m < 0) begin
            m = 0;
         end
         if (m > 32767) begin
            m = 32767;
         end
         w = 16'(($urandom_range(1) == 1) ? -m : m);
      end else if (pick < 85) begin
         w = 16'(int'($urandom_range(64)) - 32);
      end else begin
         case ($urandom_range(4))
            0: w = 16'sh7FFF;
            1: w = 16'sh8000;
            2: w = 16'sd0;
            3: w = 16'sd1;
            default: w = -16'sd1;
         endcase
      end
      return w;
   endfunction

   // One random word aimed at the working set of loaded vertices.
   task automatic send_random_item(input int idle_pct);
      int unsigned pick;
      int unsigned slot;
      logic [11:0] idx;
      logic [1:0]  act;
      pick = $urandom_range(99);
      slot = $urandom_range(HOT_COUNT - 1);
      idx  = hot_index[slot];
      if (pick < 15) begin
         act = ACT_LOAD;
         // Some loads bring a fresh vertex into the working set.
         if ($urandom_range(2) == 0) begin
            idx             = 12'($urandom);
            hot_index[slot] = idx;
         end
      end else if (pick < 75) begin
         act = ACT_APPLY;
      end else if (pick < 93) begin
         act = ACT_READ;
      end else begin
         act = ACT_SPARE;
      end
      offer_item(act, idx, random_q16(), random_q16(), random_q16(), random_weight(),
                 1'($urandom), idle_pct);
   endtask

   initial begin
      logic [14:0] phase_floor [PHASES];
      int          n;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_READ;
      req_ch.vertex_index = '0;
      req_ch.value_x      = '0;
      req_ch.value_y      = '0;
      req_ch.value_z      = '0;
      req_ch.weight       = '0;
      req_ch.is_basic     = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.min_weight   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset threshold: extremes, skips, rounding ties, saturation.
      offer_item(ACT_LOAD, 12'd0, Q_MAX, Q_MIN, 32'sd0, 16'sd0, 1'b0, 0);
      offer_item(ACT_LOAD, 12'd4095, Q_MIN, Q_MAX, 32'sd1, 16'sh7FFF, 1'b1, 0);
      offer_item(ACT_LOAD, 12'h555, 32'sd1, -32'sd1, 32'sh0001_0000, 16'sh8000, 1'b0, 0);
      offer_item(ACT_LOAD, 12'hAAA, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 1'b1, 0);
      offer_item(ACT_APPLY, 12'd0, Q_MAX, Q_MAX, Q_MAX, 16'sh7FFF, 1'b1, 0);
      offer_item(ACT_APPLY, 12'd0, Q_MAX, Q_MIN, Q_MAX, 16'sh8000, 1'b1, 0);
      offer_item(ACT_APPLY, 12'd4095, Q_MAX, Q_MAX, Q_MAX, 16'sd0, 1'b1, 0);
      offer_item(ACT_APPLY, 12'd4095, Q_MAX, Q_MIN, -32'sd1, 16'sd1, 1'b0, 0);
      offer_item(ACT_APPLY, 12'd4095, Q_MAX, Q_MIN, -32'sd1, -16'sd1, 1'b1, 0);
      // Halfway products must round upwards, whatever their sign.
      offer_item(ACT_APPLY, 12'h555, 32'sd1, -32'sd1, 32'sd3, 16'sd8192, 1'b1, 0);
      offer_item(ACT_APPLY, 12'h555, 32'sd1, -32'sd1, -32'sd3, -16'sd8192, 1'b0, 0);
      offer_item(ACT_READ, 12'd0, 32'sd5, 32'sd6, 32'sd7, 16'sd100, 1'b1, 0);
      offer_item(ACT_SPARE, 12'd4095, Q_MIN, Q_MIN, Q_MIN, 16'sh7FFF, 1'b1, 0);
      offer_item(ACT_READ, 12'h555, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 1'b0, 0);
      // Reloading a vertex clears its basic offset.
      offer_item(ACT_LOAD, 12'd0, 32'sh1234_5678, -32'sh0765_4321, 32'sd0, 16'sd0, 1'b0, 0);
      offer_item(ACT_READ, 12'd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 1'b0, 0);
      offer_item(ACT_APPLY, 12'hAAA, Q_MAX, Q_MIN, 32'sh7FFF_0000, 16'sd16384, 1'b1, 0);
      offer_item(ACT_APPLY, 12'hAAA, Q_MAX, Q_MIN, 32'sh7FFF_0000, 16'sd16384, 1'b1, 0);
      offer_item(ACT_APPLY, 12'hAAA, Q_MIN, Q_MIN, Q_MIN, 16'sh8000, 1'b1, 0);
      offer_item(ACT_READ, 12'hAAA, Q_MAX, Q_MAX, Q_MAX, 16'sh7FFF, 1'b1, 0);

      // Load the working set, so that every later apply or read finds a loaded vertex.
      hot_index[0] = 12'd0;
      hot_index[1] = 12'd4095;
      hot_index[2] = 12'h555;
      hot_index[3] = 12'hAAA;
      for (n = 4; n < HOT_COUNT; n++) begin
         hot_index[n] = 12'($urandom);
      end
      for (n = 0; n < HOT_COUNT; n++) begin
         offer_item(ACT_LOAD, hot_index[n], random_q16(), random_q16(), random_q16(),
                    random_weight(), 1'($urandom), 19);
      end

      // Random phases, each under its own threshold.
      phase_floor = '{15'd0, 15'd32767, 15'd1, 15'($urandom_range(32767)), 15'd200};
      for (int p = 0; p < PHASES; p++) begin
         write_min_weight(phase_floor[p]);
         rsp_idle_pct = (p == 1) ? 0 : 19;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // The result side holds off while words keep coming, so the block backs up.
            if (p == 0 && n == 100) begin
               hold_go = ~hold_go;
            end
            if (p == 2 && n == 180) begin
               drain_results();
            end
            send_random_item((p == 1 || (p == 0 && n >= 100 && n < 150)) ? 0 : 19);
         end
      end

      drain_results();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("weighted_morph_target_accumulator verification clean");
      end else begin
         $display("weighted_morph_target_accumulator verification failed");
      end
      $finish;
   end

endmodule

### weighted_morph_target_accumulator.f
design/wmta_pkg.sv
design/wmta_req_if.sv
design/wmta_rsp_if.sv
design/wmta_csr_if.sv
design/wmta_store.sv
design/wmta_datapath.sv
design/weighted_morph_target_accumulator.sv
tb/wmta_vertex_checker.sv
tb/tb_weighted_morph_target_accumulator.sv
